// ===== rtl/core/s20sc_pkg.sv =====
// Shared types, constants and helper functions for the Salsa20 byte cipher.
// No dependencies; every other file in rtl/core imports this package.
package s20sc_pkg;

   // Round count; odd counts are run as the next even number of half rounds
   localparam int ROUND_COUNT = 20;
   localparam int HALF_ROUNDS = ((ROUND_COUNT + 1) / 2) * 2;
   localparam int HALF_W      = $clog2(HALF_ROUNDS);

   localparam int DATA_W = 8;
   localparam int WORD_W = 32;
   localparam int NWORDS = 16;
   localparam int REG_W  = 64;
   localparam int ADDR_W = 6;
   localparam int POS_W  = 6;

   // Input-block constants "aexpnd 32-byte k" (big-endian ASCII), not the standard Salsa20 sigma words
   localparam logic [WORD_W-1:0] SIGMA0 = 32'h6165_7870;
   localparam logic [WORD_W-1:0] SIGMA1 = 32'h6e64_2033;
   localparam logic [WORD_W-1:0] SIGMA2 = 32'h322d_6279;
   localparam logic [WORD_W-1:0] SIGMA3 = 32'h7465_206b;

   // Rotation amounts of the four quarter-round steps
   localparam int ROT_S0 = 7;
   localparam int ROT_S1 = 9;
   localparam int ROT_S2 = 13;
   localparam int ROT_S3 = 18;

   localparam logic [1:0] LANE_LAST = 2'd3;

   typedef logic [NWORDS-1:0][WORD_W-1:0] words_type;

   // Register indexes (byte address = 8 * index)
   typedef enum logic [2:0] {
      REG_KEY0,
      REG_KEY1,
      REG_KEY2,
      REG_KEY3,
      REG_NONCE,
      REG_START
   } csr_idx_type;

   // Quarter-round step: which word gets updated
   typedef enum logic [1:0] {
      QS_B,
      QS_C,
      QS_D,
      QS_A
   } qstep_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_ROUND,
      SEQ_FINISH
   } seq_state_type;

   typedef struct packed {
      logic [3:0][REG_W-1:0] key;
      logic [REG_W-1:0]      nonce;
      logic [REG_W-1:0]      start;
      logic                  ctr_load;
   } cfg_type;

   typedef struct packed {
      logic      idle;
      logic      round;
      qstep_type qstep;
      logic      lane_end;
      logic      half_end;
      logic      finish;
   } seq_ctrl_type;

   // Input block from constants, key, nonce and block counter
   function automatic words_type build_init(input cfg_type cfg,
                                            input logic [REG_W-1:0] ctr);
      words_type w;
      w[0]  = SIGMA0;
      w[1]  = cfg.key[0][WORD_W-1:0];
      w[2]  = cfg.key[0][REG_W-1:WORD_W];
      w[3]  = cfg.key[1][WORD_W-1:0];
      w[4]  = cfg.key[1][REG_W-1:WORD_W];
      w[5]  = SIGMA1;
      w[6]  = cfg.nonce[WORD_W-1:0];
      w[7]  = cfg.nonce[REG_W-1:WORD_W];
      w[8]  = ctr[WORD_W-1:0];
      w[9]  = ctr[REG_W-1:WORD_W];
      w[10] = SIGMA2;
      w[11] = cfg.key[2][WORD_W-1:0];
      w[12] = cfg.key[2][REG_W-1:WORD_W];
      w[13] = cfg.key[3][WORD_W-1:0];
      w[14] = cfg.key[3][REG_W-1:WORD_W];
      w[15] = SIGMA3;
      return w;
   endfunction

   // Diagonal shift: brings the next column quarter-round onto column 0
   function automatic words_type rot_diag(input words_type v);
      words_type w;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            w[4*r+c] = v[4*((r+1)%4) + ((c+1)%4)];
         end
      end
      return w;
   endfunction

   // Matrix transpose: turns a row round into a column round
   function automatic words_type transpose(input words_type v);
      words_type w;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            w[4*r+c] = v[4*c+r];
         end
      end
      return w;
   endfunction

endpackage

// ===== rtl/core/s20sc_if.sv =====
// Valid/ready channel interfaces for the Salsa20 byte cipher.
// Depends on s20sc_pkg for payload widths.
interface s20sc_req_if;
   import s20sc_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_in;
   logic              last_of_message;

   modport source (output valid, data_in, last_of_message, input ready);
   modport sink   (input valid, data_in, last_of_message, output ready);
endinterface

interface s20sc_rsp_if;
   import s20sc_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_out;
   logic              last_out;

   modport source (output valid, data_out, last_out, input ready);
   modport sink   (input valid, data_out, last_out, output ready);
endinterface

// ===== rtl/core/s20sc_qstep.sv =====
// Shared quarter-round step unit: target ^ rotl(op_a + op_b, s[step]).
// Depends on s20sc_pkg.
module s20sc_qstep (
   input  s20sc_pkg::qstep_type        step_sel,
   input  logic [s20sc_pkg::WORD_W-1:0] op_a,
   input  logic [s20sc_pkg::WORD_W-1:0] op_b,
   input  logic [s20sc_pkg::WORD_W-1:0] target,
   output logic [s20sc_pkg::WORD_W-1:0] result
);
   import s20sc_pkg::*;

   logic [WORD_W-1:0] sum;
   logic [WORD_W-1:0] rotated;

   // One add, a constant rotate picked by step, one xor
   always_comb begin
      sum = op_a + op_b;
      case (step_sel)
         QS_B:    rotated = (sum << ROT_S0) | (sum >> (WORD_W - ROT_S0));
         QS_C:    rotated = (sum << ROT_S1) | (sum >> (WORD_W - ROT_S1));
         QS_D:    rotated = (sum << ROT_S2) | (sum >> (WORD_W - ROT_S2));
         QS_A:    rotated = (sum << ROT_S3) | (sum >> (WORD_W - ROT_S3));
         default: rotated = sum;
      endcase
      result = target ^ rotated;
   end

endmodule

// ===== rtl/core/s20sc_seq.sv =====
// Round sequencer: steps the shared unit through every quarter-round step
// of a block, then through the feed-forward state. Depends on s20sc_pkg.
module s20sc_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output s20sc_pkg::seq_ctrl_type ctrl
);
   import s20sc_pkg::*;

   seq_state_type     state_ff, state_in;
   qstep_type         qstep_ff, qstep_in;
   logic [1:0]        lane_ff, lane_in;
   logic [HALF_W-1:0] half_ff, half_in;
   logic              lane_end, half_end, last_step;

   // State and step counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         qstep_ff <= QS_B;
         lane_ff  <= '0;
         half_ff  <= '0;
      end else begin
         state_ff <= state_in;
         qstep_ff <= qstep_in;
         lane_ff  <= lane_in;
         half_ff  <= half_in;
      end
   end

   // Next state and control outputs
   always_comb begin
      lane_end  = (state_ff == SEQ_ROUND) && (qstep_ff == QS_A);
      half_end  = lane_end && (lane_ff == LANE_LAST);
      last_step = half_end && (half_ff == HALF_W'(HALF_ROUNDS - 1));

      state_in = state_ff;
      qstep_in = qstep_ff;
      lane_in  = lane_ff;
      half_in  = half_ff;

      case (state_ff)
         SEQ_IDLE: begin
            qstep_in = QS_B;
            lane_in  = '0;
            half_in  = '0;
            if (start) begin
               state_in = SEQ_ROUND;
            end
         end
         SEQ_ROUND: begin
            qstep_in = qstep_type'(qstep_ff + 2'd1);
            if (lane_end) begin
               lane_in = lane_ff + 2'd1;
            end
            if (half_end) begin
               half_in = half_ff + HALF_W'(1);
            end
            if (last_step) begin
               state_in = SEQ_FINISH;
            end
         end
         SEQ_FINISH: begin
            state_in = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase

      ctrl.idle     = (state_ff == SEQ_IDLE);
      ctrl.round    = (state_ff == SEQ_ROUND);
      ctrl.qstep    = qstep_ff;
      ctrl.lane_end = lane_end;
      ctrl.half_end = half_end;
      ctrl.finish   = (state_ff == SEQ_FINISH);
   end

endmodule

// ===== rtl/core/s20sc_csr.sv =====
// APB-style register file: key, nonce and start counter, 64 bits each.
// Depends on s20sc_pkg.
module s20sc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [s20sc_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [s20sc_pkg::REG_W-1:0]    csr_pwdata,
   output logic [s20sc_pkg::REG_W-1:0]    csr_prdata,
   output logic                           csr_pready,
   output s20sc_pkg::cfg_type             cfg
);
   import s20sc_pkg::*;

   logic [3:0][REG_W-1:0] key_ff, key_in;
   logic [REG_W-1:0]      nonce_ff, nonce_in;
   logic [REG_W-1:0]      start_ff, start_in;
   logic                  wr_en;
   csr_idx_type           idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         nonce_ff <= '0;
         start_ff <= '0;
      end else begin
         key_ff   <= key_in;
         nonce_ff <= nonce_in;
         start_ff <= start_in;
      end
   end

   // Write decode; addresses past the last register are ignored
   always_comb begin
      wr_en    = csr_psel && csr_penable && csr_pwrite;
      idx      = csr_idx_type'(csr_paddr[ADDR_W-1:3]);
      key_in   = key_ff;
      nonce_in = nonce_ff;
      start_in = start_ff;
      cfg.ctr_load = 1'b0;
      if (wr_en) begin
         case (idx)
            REG_KEY0:  key_in[0] = csr_pwdata;
            REG_KEY1:  key_in[1] = csr_pwdata;
            REG_KEY2:  key_in[2] = csr_pwdata;
            REG_KEY3:  key_in[3] = csr_pwdata;
            REG_NONCE: nonce_in  = csr_pwdata;
            REG_START: begin
               start_in     = csr_pwdata;
               cfg.ctr_load = 1'b1;
            end
            default: ;
         endcase
      end
      cfg.key   = key_ff;
      cfg.nonce = nonce_ff;
      cfg.start = start_in;
   end

   // Read mux
   always_comb begin
      csr_pready = 1'b1;
      case (idx)
         REG_KEY0:  csr_prdata = key_ff[0];
         REG_KEY1:  csr_prdata = key_ff[1];
         REG_KEY2:  csr_prdata = key_ff[2];
         REG_KEY3:  csr_prdata = key_ff[3];
         REG_NONCE: csr_prdata = nonce_ff;
         REG_START: csr_prdata = start_ff;
         default:   csr_prdata = '0;
      endcase
   end

endmodule

// ===== rtl/core/salsa20_stream_cipher.sv =====
// Salsa20 byte cipher. A byte at block position 0 starts a block build that
// runs every quarter-round step on the one shared quarter-round step unit,
// then a feed-forward state, in which the result of that byte is registered.
// Every other byte gives its result the cycle after accept, one per cycle
// while the result side keeps taking them. Synchronous active-high reset clears
// registers, position and counter; the keystream words are undefined until built.
module salsa20_stream_cipher (
   input  logic                         clock,
   input  logic                         reset,
   s20sc_req_if.sink                    req_chan,
   s20sc_rsp_if.source                  rsp_chan,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [s20sc_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [s20sc_pkg::REG_W-1:0]  csr_pwdata,
   output logic [s20sc_pkg::REG_W-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import s20sc_pkg::*;

   cfg_type           cfg;
   seq_ctrl_type      ctrl;

   words_type         w_ff, w_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              last_ff, last_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [REG_W-1:0]  ctr_ff, ctr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   words_type         init_words, round_words, ff_words;
   logic [WORD_W-1:0] step_result;
   logic [WORD_W-1:0] ks_word;
   logic [DATA_W-1:0] ks_byte, emit_data;
   logic              accept, start, emit_now, emit, emit_last;

   s20sc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   s20sc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .ctrl  (ctrl)
   );

   // Quarter-round column always sits in column 0: update row 1 from rows 0, 3
   s20sc_qstep u_qstep (
      .step_sel (ctrl.qstep),
      .op_a     (w_ff[0]),
      .op_b     (w_ff[12]),
      .target   (w_ff[4]),
      .result   (step_result)
   );

   // Handshake
   assign req_chan.ready    = ctrl.idle && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.data_out = rsp_data_ff;
   assign rsp_chan.last_out = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         ctr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         ctr_ff       <= ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      data_ff     <= data_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Step result, column shift, then diagonal shift and transpose at boundaries
   always_comb begin
      round_words     = w_ff;
      round_words[0]  = step_result;
      round_words[4]  = w_ff[8];
      round_words[8]  = w_ff[12];
      round_words[12] = w_ff[0];
      if (ctrl.lane_end) begin
         round_words = rot_diag(round_words);
      end
      if (ctrl.half_end) begin
         round_words = transpose(round_words);
      end
   end

   // Feed-forward of the input block
   always_comb begin
      init_words = build_init(cfg, ctr_ff);
      for (int k = 0; k < NWORDS; k++) begin
         ff_words[k] = w_ff[k] + init_words[k];
      end
   end

   // Item flow, keystream byte select, position and counter
   always_comb begin
      accept   = req_chan.valid && req_chan.ready;
      start    = accept && (pos_ff == '0);
      emit_now = accept && (pos_ff != '0);
      emit     = emit_now || ctrl.finish;

      ks_word = ctrl.finish ? ff_words[0] : w_ff[pos_ff[POS_W-1:2]];
      ks_byte = ctrl.finish ? ks_word[DATA_W-1:0]
                            : ks_word[{pos_ff[1:0], 3'b000} +: DATA_W];
      emit_data = emit_now ? req_chan.data_in : data_ff;
      emit_last = emit_now ? req_chan.last_of_message : last_ff;

      w_in         = w_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      ctr_in       = ctr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (accept) begin
         data_in = req_chan.data_in;
         last_in = req_chan.last_of_message;
      end

      if (start) begin
         w_in = init_words;
      end else if (ctrl.round) begin
         w_in = round_words;
      end else if (ctrl.finish) begin
         w_in   = ff_words;
         ctr_in = ctr_ff + REG_W'(1);
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data ^ ks_byte;
         rsp_last_in  = emit_last;
         if (emit_last) begin
            pos_in = '0;
            ctr_in = cfg.start;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Writing the start counter reloads the block counter at once
      if (cfg.ctr_load) begin
         ctr_in = cfg.start;
      end
   end

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      !ctrl.idle |-> !req_chan.ready)
      else $error("item taken while a block is being built");

   a_start_runs_rounds: assert property (@(posedge clock) disable iff (reset)
      start |=> ctrl.round)
      else $error("block build did not start after item at position zero");

   a_finish_emits: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |=> rsp_valid_ff)
      else $error("no result after block build");

   a_pos_after_block: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish && !last_ff |=> pos_ff == POS_W'(1))
      else $error("position did not advance after first byte of block");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the Salsa20/20 byte cipher (salsa20_stream_cipher).
// Holds its own Salsa20 keystream predictor; depends on s20sc_pkg, s20sc_req_if
// and s20sc_rsp_if from the RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import s20sc_pkg::*;

   localparam int QUIET_LIMIT   = 2000;  // cycles with no item moving on either channel
   localparam int SETTLE_CYCLES = 330;   // longer than one block build

   typedef logic [15:0][31:0] block_type;
   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
   } cipher_byte_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_psel, csr_penable, csr_pwrite;
   logic [ADDR_W-1:0]     csr_paddr;
   logic [REG_W-1:0]      csr_pwdata, csr_prdata;
   logic                  csr_pready;

   s20sc_req_if req_if();
   s20sc_rsp_if rsp_if();

   salsa20_stream_cipher dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: register copies, block counter, position, current keystream
   logic [63:0]  key_reg [4];
   logic [63:0]  nonce_reg, start_reg, block_ctr;
   logic [5:0]   byte_pos;
   block_type    keystream;

   cipher_byte_type expected_bytes [$];
   int unsigned  data_errors, csr_errors;
   int unsigned  results_taken, results_seen, rsp_stall, quiet_cycles, msg_remaining;
   bit           req_burst, rsp_burst;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic block_type mix_column(input block_type w, input int a, input int b,
                                            input int c, input int d);
      w[b] ^= rotl32(w[a] + w[d], ROT_S0);
      w[c] ^= rotl32(w[b] + w[a], ROT_S1);
      w[d] ^= rotl32(w[c] + w[b], ROT_S2);
      w[a] ^= rotl32(w[d] + w[c], ROT_S3);
      return w;
   endfunction

   // Full Salsa20 block: column/row double rounds, then feed-forward
   function automatic block_type keystream_block(input logic [63:0] ctr);
      block_type init, w;
      init = {SIGMA3, key_reg[3][63:32], key_reg[3][31:0], key_reg[2][63:32],
              key_reg[2][31:0], SIGMA2, ctr[63:32], ctr[31:0],
              nonce_reg[63:32], nonce_reg[31:0], SIGMA1, key_reg[1][63:32],
              key_reg[1][31:0], key_reg[0][63:32], key_reg[0][31:0], SIGMA0};
      w = init;
      for (int r = 0; r < ROUND_COUNT; r += 2) begin
         w = mix_column(w, 0, 4, 8, 12);
         w = mix_column(w, 5, 9, 13, 1);
         w = mix_column(w, 10, 14, 2, 6);
         w = mix_column(w, 15, 3, 7, 11);
         w = mix_column(w, 0, 1, 2, 3);
         w = mix_column(w, 5, 6, 7, 4);
         w = mix_column(w, 10, 11, 8, 9);
         w = mix_column(w, 15, 12, 13, 14);
      end
      for (int k = 0; k < 16; k++) begin
         w[k] = w[k] + init[k];
      end
      return w;
   endfunction

   // Cipher one byte and advance position and counter
   function automatic logic [7:0] encrypt_byte(input logic [7:0] value, input logic is_last);
      logic [7:0] ks_byte;
      if (byte_pos == 6'd0) begin
         keystream = keystream_block(block_ctr);
         block_ctr = block_ctr + 64'd1;
      end
      ks_byte = keystream[byte_pos[5:2]][byte_pos[1:0]*8 +: 8];
      if (is_last) begin
         byte_pos  = 6'd0;
         block_ctr = start_reg;
      end else begin
         byte_pos = byte_pos + 6'd1;
      end
      return value ^ ks_byte;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Send one item after a random gap; expectation is queued at acceptance
   task automatic send_byte(input logic [7:0] value, input logic is_last);
      int unsigned     gap;
      cipher_byte_type result;
      gap = req_burst ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.data_in         <= value;
      req_if.last_of_message <= is_last;
      do @(posedge clock); while (!req_if.ready);
      result.data    = encrypt_byte(value, is_last);
      result.is_last = is_last;
      expected_bytes.push_back(result);
   endtask

   // Stop sending and wait for every outstanding result
   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_KEY0:  key_reg[0] = value;
         REG_KEY1:  key_reg[1] = value;
         REG_KEY2:  key_reg[2] = value;
         REG_KEY3:  key_reg[3] = value;
         REG_NONCE: nonce_reg  = value;
         REG_START: begin
            start_reg = value;
            block_ctr = value;
         end
         default: ;
      endcase
   endtask

   task automatic csr_read(input csr_idx_type idx, output logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 3'b000};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_settings(input logic [63:0] k0, input logic [63:0] k1,
                                 input logic [63:0] k2, input logic [63:0] k3,
                                 input logic [63:0] nonce, input logic [63:0] start);
      wait_drained();
      csr_write(REG_KEY0, k0);
      csr_write(REG_KEY1, k1);
      csr_write(REG_KEY2, k2);
      csr_write(REG_KEY3, k3);
      csr_write(REG_NONCE, nonce);
      csr_write(REG_START, start);
   endtask

   // Reset values read as zero, then each register reads back what was written
   task automatic test_register_access();
      logic [63:0] got, value;
      csr_idx_type idx;
      for (int i = 0; i <= REG_START; i++) begin
         idx = csr_idx_type'(i);
         csr_read(idx, got);
         if (got !== 64'd0) begin
            $error("%s reset: expected %016h, got %016h", idx.name(), 64'd0, got);
            csr_errors++;
         end
         value = rand64();
         csr_write(idx, value);
         csr_read(idx, got);
         if (got !== value) begin
            $error("%s: expected %016h, got %016h", idx.name(), value, got);
            csr_errors++;
         end
      end
   endtask

   task automatic test_directed_bytes();
      req_burst = 1'b0;
      rsp_burst = 1'b0;
      // one-byte messages, each restarting from the start counter, then a longer message
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h55, 1'b1);
      send_byte(8'hAA, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b0);
      // counter write mid-message: position carries on, counter reloads
      wait_drained();
      csr_write(REG_START, 64'hFFFF_FFFF_FFFF_FFFF);
      send_byte(8'hFE, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h3C, 1'b0);
      // key and nonce change mid-block: current keystream is kept
      wait_drained();
      csr_write(REG_KEY2, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_NONCE, 64'h0000_0000_0000_0000);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h00, 1'b1);
      // next message picks up the new key and nonce
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
   endtask

   // Sender holds off until the block has returned everything
   task automatic test_drain_pause();
      req_burst = 1'b1;
      rsp_burst = 1'b0;
      for (int i = 0; i < 10; i++) begin
         send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      wait_drained();
      for (int i = 0; i < 10; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == 9);
      end
   endtask

   // Random messages, mostly short, some crossing one or two block boundaries
   task automatic test_random_traffic(input int n_items, input int unsigned first_len);
      if (first_len != 0) msg_remaining = first_len;
      for (int i = 0; i < n_items; i++) begin
         if (i % 32 == 0) begin
            req_burst = ($urandom_range(0, 3) == 0);
            rsp_burst = ($urandom_range(0, 3) == 0);
         end
         if (msg_remaining == 0) begin
            msg_remaining = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 16)
                                                        : $urandom_range(17, 140);
         end
         send_byte(8'($urandom_range(0, 255)), msg_remaining == 1);
         msg_remaining--;
      end
   endtask

   // Result checking and watchdog
   always @(posedge clock) begin
      cipher_byte_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_taken++;
         if (expected_bytes.size() == 0) begin
            $error("data_out: expected nothing, got %02h", rsp_if.data_out);
            data_errors++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_if.data_out !== want.data) begin
               $error("data_out: expected %02h, got %02h", want.data, rsp_if.data_out);
               data_errors++;
            end
            if (rsp_if.last_out !== want.is_last) begin
               $error("last_out: expected %0b, got %0b", want.is_last, rsp_if.last_out);
               data_errors++;
            end
         end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side: a fresh stall is drawn after every item taken
   initial begin
      rsp_if.ready = 1'b0;
      rsp_stall    = $urandom_range(0, 15);
      results_seen = 0;
      forever begin
         @(negedge clock);
         if (results_taken != results_seen) begin
            results_seen = results_taken;
            rsp_stall    = rsp_burst ? 0 : $urandom_range(0, 15);
         end
         if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Main sequence
   initial begin
      reset                  = 1'b1;
      req_if.valid           = 1'b0;
      req_if.data_in         = '0;
      req_if.last_of_message = 1'b0;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;
      key_reg                = '{default: 64'd0};
      nonce_reg              = 64'd0;
      start_reg              = 64'd0;
      block_ctr              = 64'd0;
      byte_pos               = 6'd0;
      keystream              = '0;
      data_errors            = 0;
      csr_errors             = 0;
      results_taken          = 0;
      quiet_cycles           = 0;
      msg_remaining          = 0;
      req_burst              = 1'b0;
      rsp_burst              = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_access();
      test_directed_bytes();
      test_drain_pause();

      apply_settings(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
      test_random_traffic(75, 0);
      // all ones: the block counter wraps to zero inside the first long message
      apply_settings('1, '1, '1, '1, '1, '1);
      test_random_traffic(75, 130);
      repeat (3) begin
         apply_settings(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
         test_random_traffic(75, 0);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (data_errors == 0 && csr_errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/s20sc_pkg.sv
rtl/core/s20sc_if.sv
rtl/core/s20sc_qstep.sv
rtl/core/s20sc_seq.sv
rtl/core/s20sc_csr.sv
rtl/core/salsa20_stream_cipher.sv
test/tb_top.sv
